// File: src/b64sd_pkg.sv
// Shared types, constants and character lookup for the base64 stream decoder.
`default_nettype none
package b64sd_pkg;

   localparam logic [7:0] PAD_CHAR  = 8'h3d;
   localparam logic [7:0] PLUS_CHAR = 8'h2b;
   localparam logic [7:0] SLASH_CHAR = 8'h2f;
   localparam logic [5:0] PLUS_VALUE  = 6'h3e;
   localparam logic [5:0] SLASH_VALUE = 6'h3f;
   localparam logic [5:0] DIGIT_BASE  = 6'h34;
   localparam logic [5:0] LOWER_BASE  = 6'h1a;

   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [1:0] byte_count;
      logic       stream_end;
   } result_type;

   function automatic sextet_type char_value(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s.valid = 1'b1;
      s.value = '0;
      d = '0;
      if (c inside {[8'h41 : 8'h5a]}) begin
         d = c - 8'h41;
         s.value = d[5:0];
      end else if (c inside {[8'h61 : 8'h7a]}) begin
         d = c - 8'h61;
         s.value = d[5:0] + LOWER_BASE;
      end else if (c inside {[8'h30 : 8'h39]}) begin
         d = c - 8'h30;
         s.value = d[5:0] + DIGIT_BASE;
      end else if (c == PLUS_CHAR) begin
         s.value = PLUS_VALUE;
      end else if (c == SLASH_CHAR) begin
         s.value = SLASH_VALUE;
      end else if (c == PAD_CHAR) begin
         s.value = '0;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// File: src/b64sd_if.sv
// Request and response channel interfaces of the base64 stream decoder.
`default_nettype none
interface b64sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       new_stream;

   modport source (output valid, output char_in, output new_stream, input ready);
   modport sink   (input valid, input char_in, input new_stream, output ready);
endinterface

interface b64sd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_a;
   logic [7:0] byte_b;
   logic [7:0] byte_c;
   logic [1:0] byte_count;
   logic       stream_end;

   modport source (output valid, output byte_a, output byte_b, output byte_c,
                   output byte_count, output stream_end, input ready);
   modport sink   (input valid, input byte_a, input byte_b, input byte_c,
                   input byte_count, input stream_end, output ready);
endinterface
`default_nettype wire

// File: src/base64_stream_decoder_top.sv
// Base64 stream decoder top level: request intake, decode core, output and skid registers.
//
// Usage: one character arrives per request on req_chan (char_in, new_stream).
// Characters outside the base64 alphabet are dropped. Every fourth valid
// character completes a group and a response with up to three bytes goes out on
// rsp_chan; a pad character in the third or fourth place closes the stream
// with one or two bytes and stream_end set. Later characters are dropped
// until a request arrives with new_stream set, which starts a fresh group.
// Throughput: one request per cycle while the skid register is empty; the decode is a
// table lookup and shift between the request handshake and the output register.
// A response is registered in the output register, or in the skid register while
// the output register holds a response that has not been taken.
// Reset clears the group and the end flag and empties both response registers.
// Receiver stall: a response waits in the output register while a second one
// can still land in the skid register; req_chan.ready drops only while the
// skid register is occupied.
`default_nettype none
module base64_stream_decoder_top (
   input  wire logic  clock,
   input  wire logic  reset,
   b64sd_req_if.sink   req_chan,
   b64sd_rsp_if.source rsp_chan
);
   import b64sd_pkg::*;

   logic       accept;
   logic       take;
   logic       res_valid;
   result_type res;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign take   = out_valid_ff && rsp_chan.ready;

   b64sd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_in    (req_chan.char_in),
      .new_stream (req_chan.new_stream),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      // a new response only arrives while the skid register is empty
      if (accept && res_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.byte_a     = out_ff.byte_a;
   assign rsp_chan.byte_b     = out_ff.byte_b;
   assign rsp_chan.byte_c     = out_ff.byte_c;
   assign rsp_chan.byte_count = out_ff.byte_count;
   assign rsp_chan.stream_end = out_ff.stream_end;

endmodule
`default_nettype wire

// File: src/b64sd_core.sv
// Group accumulation state and byte assembly for one character per cycle while accept is high.
`default_nettype none
module b64sd_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            char_in,
   input  wire logic                  new_stream,
   output logic                       res_valid,
   output b64sd_pkg::result_type      res
);
   import b64sd_pkg::*;

   logic [1:0]  count_ff, count_in;
   logic [17:0] group_ff, group_in;
   logic        ended_ff, ended_in;

   logic [1:0]  cnt;
   logic [17:0] grp;
   logic        ended_now;
   sextet_type  sx;
   logic        pad;
   logic [17:0] shifted;
   logic [23:0] full;

   always_comb begin
      // new_stream clears the group before this character is handled
      cnt       = new_stream ? 2'd0  : count_ff;
      grp       = new_stream ? 18'd0 : group_ff;
      ended_now = new_stream ? 1'b0  : ended_ff;
      sx        = char_value(char_in);
      pad       = (char_in == PAD_CHAR);
      shifted   = {grp[11:0], sx.value};
      full      = {grp, sx.value};

      count_in  = cnt;
      group_in  = grp;
      ended_in  = ended_now;
      res_valid = 1'b0;
      res       = '0;

      if (!ended_now && sx.valid) begin
         case (cnt)
            2'd0, 2'd1: begin
               group_in = shifted;
               count_in = cnt + 2'd1;
            end
            COUNT_TWO: begin
               if (pad) begin
                  res_valid      = 1'b1;
                  res.byte_a     = shifted[17:10];
                  res.byte_count = COUNT_ONE;
                  res.stream_end = 1'b1;
                  group_in       = '0;
                  count_in       = '0;
                  ended_in       = 1'b1;
               end else begin
                  group_in = shifted;
                  count_in = COUNT_THREE;
               end
            end
            default: begin
               res_valid  = 1'b1;
               res.byte_a = full[23:16];
               res.byte_b = full[15:8];
               if (pad) begin
                  res.byte_count = COUNT_TWO;
                  res.stream_end = 1'b1;
                  ended_in       = 1'b1;
               end else begin
                  res.byte_c     = full[7:0];
                  res.byte_count = COUNT_THREE;
               end
               group_in = '0;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         group_ff <= '0;
         ended_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         group_ff <= group_in;
         ended_ff <= ended_in;
      end
   end

endmodule
`default_nettype wire

// File: src/b64sd_checker.sv
// Port-level assertions for the base64 stream decoder and their bind.
`default_nettype none
module b64sd_port_assert (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] byte_b,
   input wire logic [7:0] byte_c,
   input wire logic [1:0] byte_count,
   input wire logic       stream_end
);
   import b64sd_pkg::*;

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> byte_count != 2'd0)
      else $error("response with zero bytes");

   // a padded group never carries three bytes
   a_end_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stream_end |-> byte_count != COUNT_THREE)
      else $error("stream end with full group");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_count == COUNT_ONE |-> byte_b == 8'd0 && byte_c == 8'd0)
      else $error("unused bytes not cleared");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind base64_stream_decoder_top b64sd_port_assert u_b64sd_port_assert (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .byte_b     (rsp_chan.byte_b),
   .byte_c     (rsp_chan.byte_c),
   .byte_count (rsp_chan.byte_count),
   .stream_end (rsp_chan.stream_end)
);
`default_nettype wire

// File: bench/b64sd_checker.sv
`timescale 1ns / 100ps
// Checker for the base64 stream decoder: predicts decoded bytes and compares responses.
module b64sd_checker (
   input  wire logic clock,
   input  wire logic reset,
   b64sd_req_if      req,
   b64sd_rsp_if      rsp,
   output int        fail_count,
   output int        pending_count
);
   import b64sd_pkg::*;

   logic [1:0]  group_len;
   logic [17:0] group_acc;
   logic        stream_closed;
   result_type  decoded_q[$];

   // {in_alphabet, sextet}
   function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a") + LOWER_BASE};
      if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0") + DIGIT_BASE};
      if (c == PLUS_CHAR) return {1'b1, PLUS_VALUE};
      if (c == SLASH_CHAR) return {1'b1, SLASH_VALUE};
      if (c == PAD_CHAR) return {1'b1, 6'd0};
      return 7'd0;
   endfunction

   task automatic decode_char(input logic [7:0] c, input logic fresh);
      logic [6:0]  sx;
      logic [23:0] full;
      result_type  r;
      if (fresh) begin
         group_len = '0;
         group_acc = '0;
         stream_closed = 1'b0;
      end
      if (stream_closed) return;
      sx = sextet_lookup(c);
      if (!sx[6]) return;
      if (group_len == 2'd3) begin
         full = {group_acc, sx[5:0]};
         r.byte_a = full[23:16];
         r.byte_b = full[15:8];
         if (c == PAD_CHAR) begin
            r.byte_c = '0;
            r.byte_count = COUNT_TWO;
            r.stream_end = 1'b1;
            stream_closed = 1'b1;
         end else begin
            r.byte_c = full[7:0];
            r.byte_count = COUNT_THREE;
            r.stream_end = 1'b0;
         end
         decoded_q.push_back(r);
         group_len = '0;
         group_acc = '0;
      end else begin
         group_acc = {group_acc[11:0], sx[5:0]};
         // pad as third character closes the stream with a single byte
         if (group_len == 2'd2 && c == PAD_CHAR) begin
            r.byte_a = group_acc[17:10];
            r.byte_b = '0;
            r.byte_c = '0;
            r.byte_count = COUNT_ONE;
            r.stream_end = 1'b1;
            decoded_q.push_back(r);
            group_len = '0;
            group_acc = '0;
            stream_closed = 1'b1;
         end else begin
            group_len = group_len + 2'd1;
         end
      end
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] seen);
      if (seen !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         group_len = '0;
         group_acc = '0;
         stream_closed = 1'b0;
         decoded_q.delete();
      end else begin
         // a response always stems from an earlier request, so compare first
         if (rsp.valid && rsp.ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: expected no response, got %0h %0h %0h count %0d end %0b",
                        $time, rsp.byte_a, rsp.byte_b, rsp.byte_c, rsp.byte_count,
                        rsp.stream_end);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               check_field("byte_a", want.byte_a, rsp.byte_a);
               check_field("byte_b", want.byte_b, rsp.byte_b);
               check_field("byte_c", want.byte_c, rsp.byte_c);
               check_field("byte_count", 8'(want.byte_count), 8'(rsp.byte_count));
               check_field("stream_end", 8'(want.stream_end), 8'(rsp.stream_end));
            end
         end
         if (req.valid && req.ready) decode_char(req.char_in, req.new_stream);
      end
      pending_count = decoded_q.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the base64 stream decoder: clock, reset, request stimulus and verdict.
module tb_top;
   import b64sd_pkg::*;

   localparam int ITEM_TARGET    = 1350;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   bit   clock;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   sent_items;
   int   quiet_cycles;
   int   rx_hold;
   bit   rx_fired;
   bit   tx_steady;
   bit   rx_steady;

   b64sd_req_if req_if ();
   b64sd_rsp_if rsp_if ();

   base64_stream_decoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   b64sd_checker decode_watch (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side: random stall after every taken response, except in the rx_steady phases
   always @(posedge clock) rx_fired <= rsp_if.valid && rsp_if.ready;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_hold = 0;
      end else if (rx_fired) begin
         rx_hold = rx_steady ? 0 : $urandom_range(0, 5);
         rsp_if.ready <= (rx_hold == 0);
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_if.ready <= (rx_hold == 0);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("base64_stream_decoder_top: mismatch");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic fresh);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.char_in <= c;
      req_if.new_stream <= fresh;
      do @(posedge clock); while (!req_if.ready);
      sent_items++;
   endtask

   task automatic send_text(input string s, input logic fresh_first);
      foreach (s[i]) send_char(s[i], fresh_first && i == 0);
   endtask

   task automatic send_noise(input logic fresh);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
             c == PLUS_CHAR || c == SLASH_CHAR || c == PAD_CHAR);
      send_char(c, fresh);
   endtask

   // stream with random content, left open, padded or truncated, sprinkled with skipped bytes
   task automatic send_stream();
      int groups, finish, total, pos, idx;
      logic [7:0] c;
      logic fresh;
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      finish = $urandom_range(0, 3);   // open, pad third, pad fourth, truncated
      total = groups * 4;
      if (finish == 3) total = total - $urandom_range(1, 3);
      fresh = 1'b1;
      for (pos = 0; pos < total; pos++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise(fresh);
            fresh = 1'b0;
         end
         idx = $urandom_range(0, 63);
         if (idx < 26) c = 8'("A" + idx);
         else if (idx < 52) c = 8'("a" + idx - 26);
         else if (idx < 62) c = 8'("0" + idx - 52);
         else if (idx == 62) c = PLUS_CHAR;
         else c = SLASH_CHAR;
         if (pos >= total - 4 && ((finish == 1 && pos % 4 >= 2) || (finish == 2 && pos % 4 == 3)))
            c = PAD_CHAR;
         else if (pos % 4 < 2 && $urandom_range(0, 19) == 0)
            c = PAD_CHAR;   // leading pad decodes as zero
         send_char(c, fresh);
         fresh = 1'b0;
      end
      // characters after the end of a stream are dropped
      if (finish inside {1, 2} && $urandom_range(0, 3) == 0) send_text("QUJD", 1'b0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.char_in = '0;
      req_if.new_stream = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("QUJD", 1'b1);
      send_text("////", 1'b0);
      send_char(PLUS_CHAR, 1'b0);
      send_char(8'h00, 1'b0);
      send_char("9", 1'b0);
      send_char(8'hff, 1'b0);
      send_char("z", 1'b0);
      send_text("==AA", 1'b1);   // new stream flagged in the middle of a group
      send_text("QUI=", 1'b0);
      send_text("QQ==", 1'b1);   // second pad lands after the end

      for (int phase = 0; phase < 6; phase++) begin
         tx_steady = (phase == 1 || phase == 3);
         rx_steady = (phase == 1 || phase == 4);
         while (sent_items < ITEM_TARGET * (phase + 1) / 6) begin
            if ($urandom_range(0, 6) == 0)
               send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            else
               send_stream();
         end
         if (phase == 2) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("base64_stream_decoder_top: match");
      else
         $display("base64_stream_decoder_top: mismatch");
      $finish;
   end

endmodule
